[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, ignored while reset is high
`define CHK_SAME(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// implication checked at the next edge, also active during reset
`define CHK_NEXT(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[sv/scrr_pkg.sv]
// constants, codes and reply helpers of the serial card reader responder
`default_nettype none
package scrr_pkg;

  localparam int BLOCK_BYTES   = 8;
  localparam int CARD_BYTES    = 2048;
  localparam int REPLY_BYTES   = 256;
  localparam int MAX_BLOCKS    = 31;
  localparam int REQUEST_BYTES = 512;

  localparam int CARD_AW  = $clog2(CARD_BYTES);
  localparam int REQ_AW   = $clog2(REQUEST_BYTES);
  localparam int CNT_W    = REQ_AW + 1;
  localparam int FIT_BLK  = (REPLY_BYTES - 7) / BLOCK_BYTES;
  localparam int BLK_LIM  = (MAX_BLOCKS < FIT_BLK) ? MAX_BLOCKS : FIT_BLK;
  localparam int BLK_W    = $clog2(BLK_LIM + 1);
  localparam int TOT_W    = 8;
  localparam int IDX_W    = 9;
  localparam int CA_W     = 16 + $clog2(BLOCK_BYTES) + IDX_W + 1;
  localparam int DATA_OFS = 6;
  localparam int COPY_OFS = 10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  localparam logic [7:0] CMD_INIT    = 8'h10;
  localparam logic [7:0] CMD_INIT2   = 8'h11;
  localparam logic [7:0] CMD_STAT14  = 8'h14;
  localparam logic [7:0] CMD_STAT15  = 8'h15;
  localparam logic [7:0] CMD_SENSE   = 8'h20;
  localparam logic [7:0] CMD_INFO    = 8'h21;
  localparam logic [7:0] CMD_CAPS    = 8'h22;
  localparam logic [7:0] CMD_STAT25  = 8'h25;
  localparam logic [7:0] CMD_STAT26  = 8'h26;
  localparam logic [7:0] CMD_STAT27  = 8'h27;
  localparam logic [7:0] CMD_QUERY   = 8'h33;
  localparam logic [7:0] CMD_READ    = 8'h34;
  localparam logic [7:0] CMD_WRITE   = 8'h35;
  localparam logic [7:0] REPLY_MARK  = 8'h10;
  localparam logic [7:0] SKIP_CODE   = 8'h04;

  // value of the reply length byte
  function automatic logic [7:0] reply_len(input logic [7:0] cmd,
                                           input logic [TOT_W-1:0] total);
    logic [7:0] len;
    begin
      case (cmd)
        CMD_INIT, CMD_INIT2, CMD_SENSE, CMD_STAT14, CMD_STAT15,
        CMD_STAT25, CMD_STAT26, CMD_STAT27, CMD_WRITE: len = 8'd2;
        CMD_INFO, CMD_CAPS, CMD_QUERY: len = 8'd10;
        CMD_READ: len = total + 8'd2;
        default: len = 8'd0;
      endcase
      return len;
    end
  endfunction

  // fixed reply bytes that do not come from the card
  function automatic logic [7:0] header_byte(input logic [7:0] cmd,
                                             input logic [7:0] sel5,
                                             input logic [7:0] len,
                                             input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    begin
      b = 8'h00;
      case (idx)
        9'd0: b = REPLY_MARK;
        9'd1: b = cmd;
        9'd3: b = len;
        9'd4: b = (cmd == CMD_SENSE && sel5 == 8'h00) ? 8'h80 : 8'h00;
        9'd5: b = (cmd == CMD_INIT) ? 8'h20 : 8'h00;
        9'd6: b = (cmd == CMD_INFO) ? 8'h81 : ((cmd == CMD_QUERY) ? 8'hff : 8'h00);
        9'd7: b = (cmd == CMD_CAPS) ? 8'h08 : ((cmd == CMD_QUERY) ? 8'hff : 8'h00);
        9'd8: b = (cmd == CMD_INFO) ? 8'h59 : 8'h00;
        9'd9: b = (cmd == CMD_INFO) ? 8'hda : 8'h00;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage
`default_nettype wire

[sv/scrr_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module scrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/serial_card_reader_responder_core.sv]
// top level: request framing, reply generation and card store control
// after reset the card store is cleared, one entry a cycle, with in_ready low
// a write or a failed access gives its word at the accept edge
// a successful read passes through S_RD: one card memory read, then the word is registered
// a frame close runs a build: S_BLD, S_CP_RD/S_CP_WR per copied byte of a block write,
// then S_SUM_RD/S_SUM_ACC per reply byte ahead of the checksum over the card memory port
`default_nettype none
module serial_card_reader_responder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic       cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       mode,
  input  wire logic [7:0] write_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] read_data,
  output logic            data_valid,
  output logic      [1:0] status,
  output logic            last_byte
);

  localparam logic [2:0] S_CLR     = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_RD      = 3'd2;
  localparam logic [2:0] S_BLD     = 3'd3;
  localparam logic [2:0] S_CP_RD   = 3'd4;
  localparam logic [2:0] S_CP_WR   = 3'd5;
  localparam logic [2:0] S_SUM_RD  = 3'd6;
  localparam logic [2:0] S_SUM_ACC = 3'd7;

  logic [2:0] state;
  logic [scrr_pkg::CARD_AW-1:0] clr_addr;
  logic enable;
  logic [scrr_pkg::CNT_W-1:0] req_count;
  logic [15:0] req_len;
  logic req_done;
  logic [7:0] b_cmd, b_len_hi, b_len_lo, b_sel5, b_st_hi, b_st_lo, b_cnt_hi, b_cnt_lo;
  logic [scrr_pkg::IDX_W-1:0] reply_sent;
  logic reply_done;
  logic [7:0] sum;
  logic [scrr_pkg::IDX_W-1:0] idx;

  logic accept;
  logic [15:0] len_next;
  logic [scrr_pkg::CNT_W-1:0] count_next;
  logic [16:0] target;
  logic [15:0] blocks_raw;
  logic [scrr_pkg::BLK_W-1:0] blocks;
  logic [scrr_pkg::TOT_W-1:0] total;
  logic [7:0] len8;
  logic [scrr_pkg::IDX_W-1:0] rlen;
  logic [scrr_pkg::CA_W-1:0] base;
  logic [scrr_pkg::IDX_W-1:0] rj;
  logic [scrr_pkg::CA_W-1:0] rd_full, rd_full_idx, wr_full;
  logic data_idx, inr_idx;
  logic [7:0] reply_byte;

  logic req_we;
  logic [scrr_pkg::REQ_AW-1:0] req_raddr;
  logic [7:0] req_rdata;
  logic card_we;
  logic [scrr_pkg::CARD_AW-1:0] card_waddr;
  logic [7:0] card_wdata, card_rdata;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // request framing
  assign len_next   = (req_count == scrr_pkg::CNT_W'(4)) ? {b_len_hi, b_len_lo} : req_len;
  assign count_next = (req_count < scrr_pkg::CNT_W'(scrr_pkg::REQUEST_BYTES)) ?
                      req_count + 1'b1 : req_count;
  assign target = ({1'b0, len_next} + 17'd5 > 17'(scrr_pkg::REQUEST_BYTES)) ?
                  17'(scrr_pkg::REQUEST_BYTES) : {1'b0, len_next} + 17'd5;
  assign req_we = accept && enable && !mode && !req_done &&
                  (req_count < scrr_pkg::CNT_W'(scrr_pkg::REQUEST_BYTES));

  // reply geometry
  assign blocks_raw = {b_cnt_hi, b_cnt_lo};
  assign blocks = (blocks_raw > 16'(scrr_pkg::BLK_LIM)) ? scrr_pkg::BLK_W'(scrr_pkg::BLK_LIM)
                                                        : blocks_raw[scrr_pkg::BLK_W-1:0];
  assign total = scrr_pkg::TOT_W'(blocks * scrr_pkg::BLOCK_BYTES);
  assign len8  = scrr_pkg::reply_len(b_cmd, total);
  assign rlen  = {1'b0, len8} + 9'd5;
  assign base  = scrr_pkg::CA_W'({b_st_hi, b_st_lo} * scrr_pkg::BLOCK_BYTES);

  // card addresses for reply data and for the block copy
  assign rj          = (state == S_IDLE) ? reply_sent : idx;
  assign rd_full     = base + scrr_pkg::CA_W'(rj - 9'(scrr_pkg::DATA_OFS));
  assign rd_full_idx = base + scrr_pkg::CA_W'(idx - 9'(scrr_pkg::DATA_OFS));
  assign wr_full     = base + scrr_pkg::CA_W'(idx);
  assign data_idx = (b_cmd == scrr_pkg::CMD_READ) && (idx >= 9'(scrr_pkg::DATA_OFS)) &&
                    (idx < 9'(scrr_pkg::DATA_OFS) + 9'(total));
  assign inr_idx  = (rd_full_idx[scrr_pkg::CA_W-1:scrr_pkg::CARD_AW] == '0);

  always_comb begin
    if (data_idx) begin
      reply_byte = inr_idx ? card_rdata : 8'h00;
    end else if (idx == rlen - 1'b1) begin
      reply_byte = sum;
    end else begin
      reply_byte = scrr_pkg::header_byte(b_cmd, b_sel5, len8, idx);
    end
  end

  assign req_raddr = scrr_pkg::REQ_AW'(idx + 9'(scrr_pkg::COPY_OFS));

  always_comb begin
    card_we    = 1'b0;
    card_waddr = wr_full[scrr_pkg::CARD_AW-1:0];
    card_wdata = req_rdata;
    if (state == S_CLR) begin
      card_we    = 1'b1;
      card_waddr = clr_addr;
      card_wdata = 8'h00;
    end else if (state == S_CP_WR) begin
      card_we = (wr_full[scrr_pkg::CA_W-1:scrr_pkg::CARD_AW] == '0);
    end
  end

  scrr_ram #(.WIDTH(8), .DEPTH(scrr_pkg::REQUEST_BYTES)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_count[scrr_pkg::REQ_AW-1:0]),
    .wdata (write_data),
    .raddr (req_raddr),
    .rdata (req_rdata)
  );

  scrr_ram #(.WIDTH(8), .DEPTH(scrr_pkg::CARD_BYTES)) u_card_ram (
    .clk   (clk),
    .we    (card_we),
    .waddr (card_waddr),
    .wdata (card_wdata),
    .raddr (rd_full[scrr_pkg::CARD_AW-1:0]),
    .rdata (card_rdata)
  );

  always_ff @(posedge clk) begin
    if (cfg_write_en) begin
      enable <= cfg_write_data;
    end
    if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end

    case (state)
      S_CLR: begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state <= S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          read_data  <= 8'h00;
          data_valid <= 1'b0;
          last_byte  <= 1'b0;
          status     <= scrr_pkg::ST_OK;
          out_valid  <= 1'b1;
          if (!enable) begin
            status <= scrr_pkg::ST_DISABLED;
          end else if (!mode) begin
            if (req_done) begin
              status <= scrr_pkg::ST_DROPPED;
            end else begin
              case (req_count)
                10'd1: b_cmd    <= write_data;
                10'd2: b_len_hi <= write_data;
                10'd3: b_len_lo <= write_data;
                10'd5: b_sel5   <= write_data;
                10'd6: b_st_hi  <= write_data;
                10'd7: b_st_lo  <= write_data;
                10'd8: b_cnt_hi <= write_data;
                10'd9: b_cnt_lo <= write_data;
                default: ;
              endcase
              req_count <= count_next;
              req_len   <= len_next;
              if (17'(count_next) == target) begin
                req_done <= 1'b1;
                state    <= S_BLD;
              end
            end
          end else begin
            if (!req_done || reply_done) begin
              status <= scrr_pkg::ST_EMPTY;
            end else if (reply_sent >= rlen) begin
              // reply ended: the request side starts over
              status     <= scrr_pkg::ST_EMPTY;
              reply_done <= 1'b1;
              req_count  <= '0;
              req_len    <= '0;
              req_done   <= 1'b0;
            end else begin
              out_valid  <= 1'b0;
              idx        <= reply_sent;
              reply_sent <= reply_sent + 1'b1;
              state      <= S_RD;
            end
          end
        end
      end
      S_RD: begin
        out_valid  <= 1'b1;
        read_data  <= reply_byte;
        data_valid <= 1'b1;
        status     <= scrr_pkg::ST_OK;
        last_byte  <= (idx + 1'b1 == rlen);
        state      <= S_IDLE;
      end
      S_BLD: begin
        reply_sent <= '0;
        reply_done <= 1'b0;
        sum        <= 8'h00;
        idx        <= '0;
        if ((b_cmd == scrr_pkg::CMD_INIT || b_cmd == scrr_pkg::CMD_INIT2) &&
            b_sel5 == scrr_pkg::SKIP_CODE) begin
          req_count <= '0;
          req_len   <= '0;
          req_done  <= 1'b0;
          state     <= S_IDLE;
        end else if (b_cmd == scrr_pkg::CMD_WRITE && total != '0) begin
          state <= S_CP_RD;
        end else begin
          state <= S_SUM_RD;
        end
      end
      S_CP_RD: begin
        state <= S_CP_WR;
      end
      S_CP_WR: begin
        if (idx == 9'(total) - 1'b1) begin
          idx   <= '0;
          state <= S_SUM_RD;
        end else begin
          idx   <= idx + 1'b1;
          state <= S_CP_RD;
        end
      end
      S_SUM_RD: begin
        state <= S_SUM_ACC;
      end
      S_SUM_ACC: begin
        sum <= sum ^ reply_byte;
        if (idx == rlen - 9'd2) begin
          state <= S_IDLE;
        end else begin
          idx   <= idx + 1'b1;
          state <= S_SUM_RD;
        end
      end
      default: state <= S_IDLE;
    endcase

    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      enable     <= 1'b0;
      out_valid  <= 1'b0;
      req_count  <= '0;
      req_len    <= '0;
      req_done   <= 1'b0;
      reply_sent <= '0;
      reply_done <= 1'b0;
      sum        <= 8'h00;
      idx        <= '0;
    end
  end

endmodule
`default_nettype wire

[sv/scrr_chk.sv]
// port level checks on the responder outputs, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module scrr_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic [7:0] read_data,
  input wire logic       data_valid,
  input wire logic [1:0] status,
  input wire logic       last_byte
);

  `CHK_SAME(a_valid_ok, clk, rst, out_valid && data_valid, status == scrr_pkg::ST_OK)
  `CHK_SAME(a_fail_clean, clk, rst, out_valid && status != scrr_pkg::ST_OK, read_data == 8'h00 && !data_valid && !last_byte)
  `CHK_SAME(a_last_has_data, clk, rst, out_valid && last_byte, data_valid)
  `CHK_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind serial_card_reader_responder_core scrr_chk u_scrr_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .read_data  (read_data),
  .data_valid (data_valid),
  .status     (status),
  .last_byte  (last_byte)
);
`default_nettype wire
